@@ rtl/core/pcw_pkg.sv @@
// ----------------------------------------------------------------------------
// pcw_pkg: shared types and constants of the PNG chunk walker
// Record kinds, chunk tags and the record structure that travels from the
// parser into the output queue.
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam logic [3:0] KIND_BADSIG  = 4'd0;
  localparam logic [3:0] KIND_HDR     = 4'd1;
  localparam logic [3:0] KIND_IDAT    = 4'd2;
  localparam logic [3:0] KIND_TEXT    = 4'd3;
  localparam logic [3:0] KIND_TIME    = 4'd4;
  localparam logic [3:0] KIND_GAMMA   = 4'd5;
  localparam logic [3:0] KIND_CHRM    = 4'd6;
  localparam logic [3:0] KIND_BKGD    = 4'd7;
  localparam logic [3:0] KIND_END     = 4'd8;
  localparam logic [3:0] KIND_SUMMARY = 4'd9;

  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_TEXT = 32'h74455874;
  localparam logic [31:0] TAG_TIME = 32'h74494D45;
  localparam logic [31:0] TAG_GAMA = 32'h67414D41;
  localparam logic [31:0] TAG_CHRM = 32'h6348524D;
  localparam logic [31:0] TAG_BKGD = 32'h624B4744;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;

  localparam logic [31:0] HDR_DATA_LEN = 32'd13;
  localparam logic [3:0]  TAIL_BYTES   = 4'd11;
  localparam logic [7:0]  NUL_SUBST    = 8'd13;
  localparam logic [31:0] IDAT_EXTRA   = 32'd12;
  localparam logic [31:0] END_EXTRA    = 32'd8;
  localparam logic [3:0]  LAST_PRELUDE = 4'd15;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  id;
    logic [31:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  // Kind of a known chunk tag; the bad-signature code stands for no match,
  // since no tag ever produces it.
  function automatic logic [3:0] tag_kind(input logic [31:0] tag);
    logic [3:0] k;
    case (tag)
      TAG_IDAT: k = KIND_IDAT;
      TAG_TEXT: k = KIND_TEXT;
      TAG_TIME: k = KIND_TIME;
      TAG_GAMA: k = KIND_GAMMA;
      TAG_CHRM: k = KIND_CHRM;
      TAG_BKGD: k = KIND_BKGD;
      TAG_IEND: k = KIND_END;
      default:  k = KIND_BADSIG;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] sig_letter(input logic [3:0] off);
    logic [7:0] c;
    case (off)
      4'd1:    c = 8'h50;
      4'd2:    c = 8'h4E;
      default: c = 8'h47;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/pcw_parser.sv @@
// ----------------------------------------------------------------------------
// pcw_parser: per-byte chunk parser
// Holds the walk state and turns each accepted byte into zero, one or two
// records in the same cycle.
// ----------------------------------------------------------------------------
module pcw_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  output pcw_pkg::push_t push
);

  typedef enum logic [1:0] {PH_SIG, PH_DATA, PH_TAIL, PH_SCAN} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] win_r, win_nxt;
  logic [3:0]  off_r, off_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  colour_r, colour_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        fin_r, fin_nxt;

  logic [63:0]   win_shift;
  logic [31:0]   total, d, acc_new, left_dec;
  logic          do_scan, start_v, p_v, s_v;
  logic [3:0]    start_kind, mkind;
  logic [31:0]   start_len;
  pcw_pkg::rec_t p, s;

  always_comb begin
    phase_nxt  = phase_r;
    win_nxt    = win_r;
    off_nxt    = off_r;
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    colour_nxt = colour_r;
    skip_nxt   = skip_r;
    fin_nxt    = fin_r;
    win_shift  = {win_r[55:0], data_byte};
    total      = (kind_r == pcw_pkg::KIND_HDR) ? pcw_pkg::HDR_DATA_LEN : win_r[63:32];
    d          = total - left_r;
    acc_new    = {acc_r[23:0], data_byte};
    left_dec   = (left_r != 32'd0) ? left_r - 32'd1 : left_r;
    do_scan    = 1'b0;
    start_v    = 1'b0;
    start_kind = pcw_pkg::KIND_HDR;
    start_len  = pcw_pkg::HDR_DATA_LEN;
    mkind      = pcw_pkg::KIND_BADSIG;
    p_v        = 1'b0;
    p          = '0;
    s_v        = 1'b0;
    s          = '0;

    if (fire && !fin_r) begin
      case (phase_r)
        PH_SIG: begin
          win_nxt = win_shift;
          if (off_r inside {[4'd1:4'd3]} && data_byte != pcw_pkg::sig_letter(off_r)) begin
            p_v     = 1'b1;
            p.kind  = pcw_pkg::KIND_BADSIG;
            p.value = {24'd0, data_byte};
            fin_nxt = 1'b1;
          end else if (off_r == pcw_pkg::LAST_PRELUDE) begin
            if (win_shift[31:0] == pcw_pkg::TAG_IHDR) begin
              start_v = 1'b1;
            end else begin
              phase_nxt = PH_SCAN;
              do_scan   = 1'b1;
            end
          end else begin
            off_nxt = off_r + 4'd1;
          end
        end
        PH_DATA: begin
          acc_nxt = acc_new;
          p.kind  = kind_r;
          case (kind_r)
            pcw_pkg::KIND_HDR: begin
              if (d == 32'd3) begin
                p_v = 1'b1; p.value = acc_new;
              end else if (d == 32'd7) begin
                p_v = 1'b1; p.id = 3'd1; p.value = acc_new;
              end else if (d inside {[32'd8:32'd12]}) begin
                p_v = 1'b1; p.id = 3'(d - 32'd6); p.value = {24'd0, data_byte};
              end
              if (d == 32'd9) colour_nxt = data_byte;
            end
            pcw_pkg::KIND_TEXT: begin
              p_v     = 1'b1;
              p.value = {24'd0, (data_byte == 8'd0) ? pcw_pkg::NUL_SUBST : data_byte};
            end
            pcw_pkg::KIND_TIME: begin
              if (d == 32'd1) begin
                p_v = 1'b1; p.value = {16'd0, acc_new[15:0]};
              end else if (d inside {[32'd2:32'd6]}) begin
                p_v = 1'b1; p.id = 3'(d - 32'd1); p.value = {24'd0, data_byte};
              end
            end
            pcw_pkg::KIND_GAMMA: begin
              if (d == 32'd3) begin
                p_v = 1'b1; p.value = acc_new;
              end
            end
            pcw_pkg::KIND_CHRM: begin
              if (d <= 32'd31 && d[1:0] == 2'd3) begin
                p_v = 1'b1; p.id = d[4:2]; p.value = acc_new;
              end
            end
            pcw_pkg::KIND_BKGD: begin
              if (colour_r inside {8'd0, 8'd4}) begin
                if (d == 32'd1) begin
                  p_v = 1'b1; p.value = {16'd0, acc_new[15:0]};
                end
              end else if (colour_r inside {8'd2, 8'd6}) begin
                if (d inside {32'd1, 32'd3, 32'd5}) begin
                  p_v = 1'b1; p.id = d[3:1]; p.value = {16'd0, acc_new[15:0]};
                end
              end else if (colour_r == 8'd3) begin
                if (d == 32'd0) begin
                  p_v = 1'b1; p.value = {24'd0, data_byte};
                end
              end
            end
            default: ;
          endcase
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_TAIL;
            off_nxt   = pcw_pkg::TAIL_BYTES;
          end
        end
        PH_TAIL: begin
          win_nxt = win_shift;
          if (off_r != 4'd0) off_nxt = off_r - 4'd1;
          if (off_nxt == 4'd0) phase_nxt = PH_SCAN;
        end
        default: begin
          win_nxt = win_shift;
          do_scan = 1'b1;
        end
      endcase

      if (do_scan) begin
        mkind = pcw_pkg::tag_kind(win_shift[31:0]);
        if (mkind == pcw_pkg::KIND_END) begin
          p_v     = 1'b1;
          p.kind  = pcw_pkg::KIND_END;
          p.value = win_shift[63:32] + pcw_pkg::END_EXTRA;
          fin_nxt = 1'b1;
          s_v     = 1'b1;
        end else if (mkind != pcw_pkg::KIND_BADSIG) begin
          if (mkind == pcw_pkg::KIND_IDAT) begin
            p_v     = 1'b1;
            p.kind  = pcw_pkg::KIND_IDAT;
            p.value = win_shift[63:32] + pcw_pkg::IDAT_EXTRA;
          end
          start_v    = 1'b1;
          start_kind = mkind;
          start_len  = win_shift[63:32];
        end else if (skip_r != '1) begin
          skip_nxt = skip_r + 32'd1;
        end
      end

      if (start_v) begin
        kind_nxt = start_kind;
        acc_nxt  = 32'd0;
        left_nxt = start_len;
        if (start_len == 32'd0) begin
          phase_nxt = PH_TAIL;
          off_nxt   = pcw_pkg::TAIL_BYTES;
        end else begin
          phase_nxt = PH_DATA;
        end
      end

      if (end_of_file && !fin_nxt) begin
        s_v     = 1'b1;
        fin_nxt = 1'b1;
      end
    end

    s.kind  = pcw_pkg::KIND_SUMMARY;
    s.value = skip_nxt;
    s.last  = 1'b1;
    p.last  = !s_v;
    push.cnt  = {1'b0, p_v} + {1'b0, s_v};
    push.rec0 = p_v ? p : s;
    push.rec1 = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      win_r    <= '0;
      off_r    <= '0;
      kind_r   <= '0;
      left_r   <= '0;
      acc_r    <= '0;
      colour_r <= '0;
      skip_r   <= '0;
      fin_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      win_r    <= win_nxt;
      off_r    <= off_nxt;
      kind_r   <= kind_nxt;
      left_r   <= left_nxt;
      acc_r    <= acc_nxt;
      colour_r <= colour_nxt;
      skip_r   <= skip_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

@@ rtl/core/pcw_out_queue.sv @@
// ----------------------------------------------------------------------------
// pcw_out_queue: result queue
// Small register queue that takes up to two records a cycle and hands one
// record a cycle to the output channel while the output does not stall.
// ----------------------------------------------------------------------------
module pcw_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  pcw_pkg::push_t push,
  input  logic           pop,
  output logic           not_empty,
  output logic           near_full,
  output pcw_pkg::rec_t  head
);

  pcw_pkg::rec_t             mem_r [pcw_pkg::QUEUE_DEPTH];
  logic [pcw_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [pcw_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic [pcw_pkg::QPTR_W-1:0] wr_p1;

  assign wr_p1     = wr_r + 1'b1;
  assign not_empty = (cnt_r != '0);
  // Room for two more records is kept so a byte that is taken always fits.
  assign near_full = (cnt_r > (pcw_pkg::QPTR_W+1)'(pcw_pkg::QUEUE_DEPTH - 2));
  assign head      = mem_r[rd_r];
  assign cnt_nxt   = cnt_r + (pcw_pkg::QPTR_W+1)'(push.cnt) - (pcw_pkg::QPTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.rec0;
    if (push.cnt == 2'd2) mem_r[wr_p1] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + pcw_pkg::QPTR_W'(push.cnt);
      rd_r  <= rd_r + pcw_pkg::QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/png_chunk_walker.sv @@
// A record is written into the output queue as its byte is taken and read from its head.
// Throughput: one byte per cycle while the input is not stalled; a byte that yields two
// records (end of walk or end of file) is absorbed by a four-entry queue.
// The input stalls only while that queue holds more than two records.
// Reset (synchronous, active low) returns to the signature prelude and empties the queue.
// ----------------------------------------------------------------------------
// png_chunk_walker: PNG chunk walker top level
// Parses a PNG byte stream and emits decoded chunk fields as records.
// ----------------------------------------------------------------------------
module png_chunk_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_record_kind,
  output logic [2:0]  out_field_id,
  output logic [31:0] out_field_value,
  output logic        out_last_of_run
);

  pcw_pkg::push_t push;
  pcw_pkg::rec_t  head;
  logic           fire, pop, near_full;

  assign fire = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;
  assign in_stall = near_full;

  pcw_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .push        (push)
  );

  pcw_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .not_empty (out_valid),
    .near_full (near_full),
    .head      (head)
  );

  assign out_record_kind = head.kind;
  assign out_field_id    = head.id;
  assign out_field_value = head.value;
  assign out_last_of_run = head.last;

endmodule

@@ rtl/core/pcw_checker.sv @@
// ----------------------------------------------------------------------------
// pcw_checker: port-level checks of the chunk walker
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module pcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_record_kind,
  input logic [31:0] out_field_value,
  input logic        out_last_of_run
);

  // A stalled transaction keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // The summary always closes the run of its byte.
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == pcw_pkg::KIND_SUMMARY |-> out_last_of_run)
    else $error("summary record not last of its run");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output queue");

endmodule

bind png_chunk_walker pcw_checker u_pcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_record_kind (out_record_kind),
  .out_field_value (out_field_value),
  .out_last_of_run (out_last_of_run)
);
